// ----- hw/rtl/e2q_pkg.sv -----
// Package for the Euler angle to quaternion core: widths, latencies and the
// fixed-point constants of the half-angle sine/cosine series.
// No dependencies.
package e2q_pkg;

    localparam int RESULT_WIDTH = 16;

    // register stages of one sincos unit, and of the product/sum back end
    localparam int SC_LAT  = 18;
    localparam int TRI_LAT = 5;
    localparam int LAT     = SC_LAT + TRI_LAT;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // half-turn wrap and quadrant split, angle units of 1/64 degree
    localparam logic [15:0] HALF_TURN = 16'd46080;
    localparam logic [15:0] QUAD_1    = 16'd11520;
    localparam logic [15:0] QUAD_2    = 16'd23040;
    localparam logic [15:0] QUAD_3    = 16'd34560;

    // xr = floor((r*K + 5760)/11520) with K = 11520*RAD_A + RAD_B
    localparam logic [17:0] RAD_A   = 18'd146408;
    localparam logic [13:0] RAD_B   = 14'd9553;
    localparam logic [12:0] RAD_RND = 13'd5760;
    localparam int          RAD_SH  = 26;
    localparam logic [20:0] RAD_REC = 21'(((64'd1 << RAD_SH) + 64'd44) / 64'd45);

    // series divisors k = 2^PRE * odd; quotient by reciprocal (M, shift RSH)
    localparam int SIN_PRE [5] = '{1, 3, 1, 2, 1};
    localparam int SIN_RSH [5] = '{37, 35, 36, 34, 33};
    localparam logic [32:0] SIN_REC [5] = '{
        33'(((64'd1 << 37) + 64'd54) / 64'd55),
        33'(((64'd1 << 35) + 64'd8) / 64'd9),
        33'(((64'd1 << 36) + 64'd20) / 64'd21),
        33'(((64'd1 << 34) + 64'd4) / 64'd5),
        33'(((64'd1 << 33) + 64'd2) / 64'd3)
    };
    localparam int COS_PRE [5] = '{2, 1, 3, 1, 2};
    localparam int COS_RSH [5] = '{37, 37, 34, 35, 33};
    localparam logic [32:0] COS_REC [5] = '{
        33'(((64'd1 << 37) + 64'd32) / 64'd33),
        33'(((64'd1 << 37) + 64'd44) / 64'd45),
        33'(((64'd1 << 34) + 64'd6) / 64'd7),
        33'(((64'd1 << 35) + 64'd14) / 64'd15),
        33'(((64'd1 << 33) + 64'd2) / 64'd3)
    };

    localparam logic [1:0] QD_0 = 2'd0;
    localparam logic [1:0] QD_1 = 2'd1;
    localparam logic [1:0] QD_2 = 2'd2;
    localparam logic [1:0] QD_3 = 2'd3;

endpackage

// ----- hw/rtl/e2q_sincos.sv -----
// Pipelined sine and cosine of a half angle, Q30 results, SC_LAT stages.
// Depends on e2q_pkg.
module e2q_sincos
    import e2q_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_angle,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    logic [15:0] n_u;
    logic [1:0]  n_q1;
    logic [13:0] n_r1;
    logic [1:0]  r_q1, r_q2, r_q3, r_q4, r_q5;
    logic [13:0] r_r1;
    logic [30:0] r_ra2, r_ra3;
    logic [26:0] r_rb2;
    logic [18:0] n_n3;
    logic [39:0] r_qd3;
    logic [30:0] r_xr4, r_xr5;
    logic [61:0] r_xsq5;

    logic [30:0] w_ts  [0:5];
    logic [30:0] w_tc  [0:5];
    logic [30:0] w_xr  [0:5];
    logic [31:0] w_xr2 [0:5];
    logic [1:0]  w_q   [0:5];

    logic [61:0] r_spf;
    logic [62:0] r_cpf;
    logic [1:0]  r_qf1, r_qf2;
    logic [31:0] n_cn;
    logic [30:0] n_half;
    logic [30:0] n_cv;
    logic [30:0] r_sv, r_cv;
    logic signed [31:0] n_sp, n_cp, r_s, r_c;

    // wrap to one half turn, split into quadrant and rest
    always_comb begin
        n_u = i_angle[15] ? (i_angle + HALF_TURN) : i_angle;
        if (n_u >= QUAD_3) begin
            n_q1 = QD_3;
            n_r1 = 14'(n_u - QUAD_3);
        end else if (n_u >= QUAD_2) begin
            n_q1 = QD_2;
            n_r1 = 14'(n_u - QUAD_2);
        end else if (n_u >= QUAD_1) begin
            n_q1 = QD_1;
            n_r1 = 14'(n_u - QUAD_1);
        end else begin
            n_q1 = QD_0;
            n_r1 = 14'(n_u);
        end
    end

    assign n_n3 = r_rb2[26:8];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1   <= n_q1;
            r_r1   <= n_r1;
            r_q2   <= r_q1;
            r_ra2  <= 31'(r_r1) * 31'(RAD_A);
            r_rb2  <= 27'(r_r1) * 27'(RAD_B) + 27'(RAD_RND);
            r_q3   <= r_q2;
            r_ra3  <= r_ra2;
            r_qd3  <= 40'(n_n3) * 40'(RAD_REC);
            r_q4   <= r_q3;
            r_xr4  <= r_ra3 + 31'(r_qd3 >> RAD_SH);
            r_q5   <= r_q4;
            r_xr5  <= r_xr4;
            r_xsq5 <= 62'(r_xr4) * 62'(r_xr4);
        end
    end

    assign w_ts[0]  = Q30_ONE;
    assign w_tc[0]  = Q30_ONE;
    assign w_xr[0]  = r_xr5;
    assign w_xr2[0] = r_xsq5[61:30];
    assign w_q[0]   = r_q5;

    // one series term per two stages: product with xr2, then divide by k
    for (genvar g = 0; g < 5; g++) begin : g_term
        logic [62:0] r_ps, r_pc;
        logic [30:0] r_xr_a, r_xr_b;
        logic [31:0] r_xr2_a, r_xr2_b;
        logic [1:0]  r_q_a, r_q_b;
        logic [63:0] r_ms, r_mc;
        logic [31:0] n_ns, n_nc;

        assign n_ns = r_ps[61:30] >> SIN_PRE[g];
        assign n_nc = r_pc[61:30] >> COS_PRE[g];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ps    <= 63'(w_xr2[g]) * 63'(w_ts[g]);
                r_pc    <= 63'(w_xr2[g]) * 63'(w_tc[g]);
                r_xr_a  <= w_xr[g];
                r_xr2_a <= w_xr2[g];
                r_q_a   <= w_q[g];
                r_ms    <= 64'(n_ns) * 64'(SIN_REC[g]);
                r_mc    <= 64'(n_nc) * 64'(COS_REC[g]);
                r_xr_b  <= r_xr_a;
                r_xr2_b <= r_xr2_a;
                r_q_b   <= r_q_a;
            end
        end

        assign w_ts[g+1]  = Q30_ONE - 31'(r_ms >> SIN_RSH[g]);
        assign w_tc[g+1]  = Q30_ONE - 31'(r_mc >> COS_RSH[g]);
        assign w_xr[g+1]  = r_xr_b;
        assign w_xr2[g+1] = r_xr2_b;
        assign w_q[g+1]   = r_q_b;
    end

    assign n_cn   = r_cpf[61:30];
    assign n_half = n_cn[31:1];
    assign n_cv   = (n_half > Q30_ONE) ? '0 : (Q30_ONE - n_half);

    // quadrant rotation of (sin, cos)
    always_comb begin
        case (r_qf2)
            QD_0: begin
                n_sp = 32'(r_sv);
                n_cp = 32'(r_cv);
            end
            QD_1: begin
                n_sp = 32'(r_cv);
                n_cp = -32'(r_sv);
            end
            QD_2: begin
                n_sp = -32'(r_sv);
                n_cp = -32'(r_cv);
            end
            default: begin
                n_sp = -32'(r_cv);
                n_cp = 32'(r_sv);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spf <= 62'(w_xr[5]) * 62'(w_ts[5]);
            r_cpf <= 63'(w_xr2[5]) * 63'(w_tc[5]);
            r_qf1 <= w_q[5];
            r_sv  <= r_spf[60:30];
            r_cv  <= n_cv;
            r_qf2 <= r_qf1;
            r_s   <= n_sp;
            r_c   <= n_cp;
        end
    end

    assign o_sin = r_s;
    assign o_cos = r_c;

endmodule

// ----- hw/rtl/euler_to_quaternion_core.sv -----
// Euler angles (roll, pitch, yaw) to rotation quaternion, Q1.15 outputs.
// Pipeline: an accepted word passes the 18-stage half-angle sincos units and
// 5 product/sum stages on its way to o_valid.
// Throughput: one word per cycle; the whole pipeline holds while a result
// waits on i_stall. Synchronous active-low reset clears the valid bits only.
// Depends on e2q_pkg and e2q_sincos.
module euler_to_quaternion_core
    import e2q_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [15:0]             i_roll_angle,
    input  logic signed [15:0]             i_pitch_angle,
    input  logic signed [15:0]             i_yaw_angle,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [RESULT_WIDTH-1:0] o_quat_x,
    output logic signed [RESULT_WIDTH-1:0] o_quat_y,
    output logic signed [RESULT_WIDTH-1:0] o_quat_z,
    output logic signed [RESULT_WIDTH-1:0] o_quat_w
);

    localparam int RND_SH = 61 - RESULT_WIDTH;
    localparam logic signed [66:0] SAT_HI = (67'sd1 <<< (RESULT_WIDTH - 1)) - 67'sd1;
    localparam logic signed [66:0] SAT_LO = -(67'sd1 <<< (RESULT_WIDTH - 1));
    localparam logic signed [66:0] RND_HALF = 67'sd1 <<< (RND_SH - 1);
    localparam logic signed [63:0] P_HALF = 64'sd1 <<< 29;

    logic            w_adv;
    logic [LAT-1:0]  r_vld;

    logic signed [31:0] w_sr, w_cr, w_sp, w_cp, w_sy, w_cy;
    logic signed [31:0] r_sy1, r_cy1, r_sy2, r_cy2;
    logic signed [63:0] r_crsp, r_srcp, r_crcp, r_srsp;
    logic signed [33:0] r_pcrsp, r_psrcp, r_pcrcp, r_psrsp;
    logic signed [65:0] r_x1, r_x2, r_y1, r_y2, r_z1, r_z2, r_w1, r_w2;
    logic signed [66:0] r_sx, r_syy, r_sz, r_sw;
    logic signed [RESULT_WIDTH-1:0] r_qx, r_qy, r_qz, r_qw;

    function automatic logic signed [RESULT_WIDTH-1:0] rnd_sat(logic signed [66:0] v);
        logic signed [66:0] t;
        t = (v + RND_HALF) >>> RND_SH;
        if (t > SAT_HI) begin
            t = SAT_HI;
        end else if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return RESULT_WIDTH'(t);
    endfunction

    function automatic logic signed [33:0] rnd30(logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v + P_HALF) >>> 30;
        return 34'(t);
    endfunction

    // pipeline moves unless a finished word is held by the sink
    assign w_adv   = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_adv;

    e2q_sincos u_roll (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (i_roll_angle),
        .o_sin   (w_sr),
        .o_cos   (w_cr)
    );

    e2q_sincos u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (i_pitch_angle),
        .o_sin   (w_sp),
        .o_cos   (w_cp)
    );

    e2q_sincos u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_angle (i_yaw_angle),
        .o_sin   (w_sy),
        .o_cos   (w_cy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // roll x pitch pairs
            r_crsp  <= 64'(w_cr) * 64'(w_sp);
            r_srcp  <= 64'(w_sr) * 64'(w_cp);
            r_crcp  <= 64'(w_cr) * 64'(w_cp);
            r_srsp  <= 64'(w_sr) * 64'(w_sp);
            r_sy1   <= w_sy;
            r_cy1   <= w_cy;
            r_pcrsp <= rnd30(r_crsp);
            r_psrcp <= rnd30(r_srcp);
            r_pcrcp <= rnd30(r_crcp);
            r_psrsp <= rnd30(r_srsp);
            r_sy2   <= r_sy1;
            r_cy2   <= r_cy1;
            // times yaw, Q60
            r_x1    <= 66'(r_pcrsp) * 66'(r_sy2);
            r_x2    <= 66'(r_psrcp) * 66'(r_cy2);
            r_y1    <= 66'(r_pcrsp) * 66'(r_cy2);
            r_y2    <= 66'(r_psrcp) * 66'(r_sy2);
            r_z1    <= 66'(r_pcrcp) * 66'(r_sy2);
            r_z2    <= 66'(r_psrsp) * 66'(r_cy2);
            r_w1    <= 66'(r_pcrcp) * 66'(r_cy2);
            r_w2    <= 66'(r_psrsp) * 66'(r_sy2);
            r_sx    <= 67'(r_x1) - 67'(r_x2);
            r_syy   <= -67'(r_y1) - 67'(r_y2);
            r_sz    <= 67'(r_z1) - 67'(r_z2);
            r_sw    <= 67'(r_w1) + 67'(r_w2);
            r_qx    <= rnd_sat(r_sx);
            r_qy    <= rnd_sat(r_syy);
            r_qz    <= rnd_sat(r_sz);
            r_qw    <= rnd_sat(r_sw);
        end
    end

    assign o_valid  = r_vld[LAT-1];
    assign o_quat_x = r_qx;
    assign o_quat_y = r_qy;
    assign o_quat_z = r_qz;
    assign o_quat_w = r_qw;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-2] && !o_stall) |=> o_valid)
        else $error("word lost at last stage");

endmodule
